// File: src/ewh_pkg.sv
`timescale 1ns / 1ps

package ewh_pkg;

   localparam int MAX_BINS_DEF = 1024;
   localparam int COUNT_W_DEF  = 32;
   localparam int VAL_W        = 64;
   localparam int BIN_W        = 11;
   localparam int TOTAL_W      = 32;
   localparam int CSR_IDX_W    = 3;
   localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW  = 3'd0,
      CSR_HIGH = 3'd1,
      CSR_BINS = 3'd2,
      CSR_SIGN = 3'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_PREP,
      ST_DIV,
      ST_FILL,
      ST_IDLE,
      ST_SCAN,
      ST_RD,
      ST_UPD
   } state_type;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_READ,
      KIND_NULL
   } kind_type;

   typedef struct packed {
      logic             func;
      logic [VAL_W-1:0] value;
      logic             is_null;
      logic [BIN_W-1:0] read_bin;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]   bin_index;
      logic [TOTAL_W-1:0] bin_total;
      logic [TOTAL_W-1:0] null_total;
      logic [VAL_W-1:0]   seen_min;
      logic [VAL_W-1:0]   seen_max;
   } rsp_type;

   // One edge as held in a cell: ordering key and valid flag.
   typedef struct packed {
      logic             vld;
      logic [VAL_W-1:0] key;
   } edge_type;

endpackage

// File: src/equal_width_histogram_accumulator.sv
`timescale 1ns / 1ps
// A read or null item is answered from the update state once the response slot
// is free; an add item first walks its token along the edge-cell chain to its bin.
// One item at a time: no new item is accepted until the last one's response is registered.
// Reset and every register write rebuild through the prep, divide and fill states
// (counts zeroed, edges shifted in), during which no item is accepted.
module equal_width_histogram_accumulator #(
   parameter int MAX_BINS    = ewh_pkg::MAX_BINS_DEF,
   parameter int COUNT_WIDTH = ewh_pkg::COUNT_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ewh_pkg::req_type              req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ewh_pkg::rsp_type              rsp,
   input  logic                          csr_we,
   input  logic [ewh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ewh_pkg::VAL_W-1:0]     csr_wdata
);

   localparam int NCELL = MAX_BINS + 1;            // most edges there can be
   localparam int DEPTH = MAX_BINS + 2;            // bins incl. under/overflow
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(MAX_BINS + 1);
   localparam int XW    = (AW > ewh_pkg::BIN_W) ? AW : ewh_pkg::BIN_W;
   localparam int VW    = ewh_pkg::VAL_W;

   // Configuration registers.
   logic [VW-1:0]               low_ff, high_ff;
   logic [ewh_pkg::BIN_W-1:0]   bins_ff;
   logic                        signed_ff;

   ewh_pkg::state_type          state_ff, state_in;
   ewh_pkg::kind_type           kind_ff;

   logic [VW-1:0]               sgn_mask;
   logic                        inverted;
   logic [VW-1:0]               len_raw, len, b64;
   logic                        inv_ff;
   logic [BW-1:0]               b_ff;
   logic [VW-1:0]               w_ff, cur_ff, last_ff;
   logic [AW-1:0]               k_ff, n_ff, idx_ff;
   logic                        div_done;
   logic [VW-1:0]               div_q;

   logic [VW-1:0]               key_ff, min_ff, max_ff;
   logic [COUNT_WIDTH-1:0]      null_ff;
   logic [ewh_pkg::BIN_W-1:0]   rbin_ff;
   logic                        rd_ok_ff;

   ewh_pkg::rsp_type            rsp_ff;
   logic                        rsp_vld_ff;

   // Edge chain.
   ewh_pkg::edge_type           edge_chain [NCELL+1];
   ewh_pkg::edge_type           push;
   logic [NCELL:0]              tok_chain;
   logic [NCELL-1:0]            stops;
   logic                        tail_ff, stop_any, shift_en, inject;

   // Count memory.
   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [COUNT_WIDTH-1:0]      ram_wdata, ram_rdata, cnt_sat;

   logic                        accept, slot_free, rd_ok, upd_fire;
   logic [VW-1:0]               v_key;

   assign sgn_mask  = signed_ff ? ewh_pkg::SIGN_BIT : '0;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_vld_ff || rsp_ready;
   assign v_key     = req.value ^ sgn_mask;
   assign rd_ok     = XW'(req.read_bin) <= XW'(n_ff);
   assign stop_any  = (|stops) || tail_ff;
   assign cnt_sat   = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;
   assign upd_fire  = (state_ff == ewh_pkg::ST_UPD) && slot_free;

   // Range length and clamped bin count from the current registers.
   always_comb begin
      inverted = (low_ff ^ sgn_mask) > (high_ff ^ sgn_mask);
      len_raw  = high_ff - low_ff;
      len      = (len_raw == ewh_pkg::ALL_ONES) ? len_raw : len_raw + 1'b1;
      b64      = VW'(bins_ff);
      if (b64 == '0) begin
         b64 = VW'(1);
      end
      if (b64 > VW'(MAX_BINS)) begin
         b64 = VW'(MAX_BINS);
      end
      if (len < b64) begin
         b64 = len;
      end
   end

   ewh_div #(.DIV_W(BW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ewh_pkg::ST_PREP),
      .dividend (len),
      .divisor  (BW'(b64)),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next edge to shift into the top of the chain during the fill sweep.
   always_comb begin
      push.vld = 1'b0;
      push.key = '0;
      if (inv_ff) begin
         push.vld = (k_ff == '0);
         push.key = sgn_mask;
      end else if (XW'(k_ff) < XW'(b_ff)) begin
         push.vld = 1'b1;
         push.key = cur_ff ^ sgn_mask;
      end else if (XW'(k_ff) == XW'(b_ff)) begin
         if ((high_ff ^ sgn_mask) != ewh_pkg::ALL_ONES) begin
            push.vld = 1'b1;
            push.key = (high_ff + 1'b1) ^ sgn_mask;
         end else if ((last_ff ^ sgn_mask) != ewh_pkg::ALL_ONES) begin
            push.vld = 1'b1;
            push.key = high_ff ^ sgn_mask;
         end
      end
   end

   assign shift_en          = (state_ff == ewh_pkg::ST_FILL) && (XW'(k_ff) < XW'(NCELL));
   assign inject            = accept && !req.func && !req.is_null;
   assign edge_chain[NCELL] = push;
   assign tok_chain[0]      = inject;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ewh_edge_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .edge_in  (edge_chain[i+1]),
         .edge_out (edge_chain[i]),
         .key_in   (key_ff),
         .tok_in   (tok_chain[i]),
         .tok_out  (tok_chain[i+1]),
         .stop_out (stops[i])
      );
   end

   ewh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ewh_pkg::ST_PREP: state_in = ewh_pkg::ST_DIV;
         ewh_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = ewh_pkg::ST_FILL;
            end
         end
         ewh_pkg::ST_FILL: begin
            if (k_ff == AW'(DEPTH - 1)) begin
               state_in = ewh_pkg::ST_IDLE;
            end
         end
         ewh_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = inject ? ewh_pkg::ST_SCAN : ewh_pkg::ST_UPD;
            end
         end
         ewh_pkg::ST_SCAN: begin
            if (stop_any) begin
               state_in = ewh_pkg::ST_RD;
            end
         end
         ewh_pkg::ST_RD: state_in = ewh_pkg::ST_UPD;
         ewh_pkg::ST_UPD: begin
            if (slot_free) begin
               state_in = ewh_pkg::ST_IDLE;
            end
         end
         default: state_in = ewh_pkg::ST_PREP;
      endcase
      // Any register write rebuilds.
      if (csr_we && (csr_index == ewh_pkg::CSR_LOW || csr_index == ewh_pkg::CSR_HIGH ||
                     csr_index == ewh_pkg::CSR_BINS || csr_index == ewh_pkg::CSR_SIGN)) begin
         state_in = ewh_pkg::ST_PREP;
      end
   end

   // Outputs: memory port and handshake.
   always_comb begin
      req_ready = (state_ff == ewh_pkg::ST_IDLE);
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = cnt_sat;
      ram_re    = 1'b0;
      ram_raddr = idx_ff;
      case (state_ff)
         ewh_pkg::ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff;
            ram_wdata = '0;
         end
         ewh_pkg::ST_IDLE: begin
            ram_re    = accept && req.func && rd_ok;
            ram_raddr = AW'(XW'(req.read_bin));
         end
         ewh_pkg::ST_RD: ram_re = 1'b1;
         ewh_pkg::ST_UPD: ram_we = slot_free && (kind_ff == ewh_pkg::KIND_ADD);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ewh_pkg::ST_PREP;
         low_ff     <= '0;
         high_ff    <= '0;
         bins_ff    <= ewh_pkg::BIN_W'(1024);
         signed_ff  <= 1'b1;
         rsp_vld_ff <= 1'b0;
         tail_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tok_chain[NCELL];
         if (csr_we) begin
            case (csr_index)
               ewh_pkg::CSR_LOW:  low_ff    <= csr_wdata;
               ewh_pkg::CSR_HIGH: high_ff   <= csr_wdata;
               ewh_pkg::CSR_BINS: bins_ff   <= ewh_pkg::BIN_W'(csr_wdata);
               ewh_pkg::CSR_SIGN: signed_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (upd_fire) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end

      case (state_ff)
         ewh_pkg::ST_PREP: begin
            // Reload running state from the limits.
            inv_ff  <= inverted;
            b_ff    <= BW'(b64);
            cur_ff  <= low_ff;
            last_ff <= low_ff;
            min_ff  <= low_ff;
            max_ff  <= high_ff;
            null_ff <= '0;
            k_ff    <= '0;
            n_ff    <= '0;
         end
         ewh_pkg::ST_DIV: w_ff <= div_q;
         ewh_pkg::ST_FILL: begin
            k_ff <= k_ff + 1'b1;
            if (shift_en && push.vld) begin
               n_ff <= n_ff + 1'b1;
            end
            if (!inv_ff && XW'(k_ff) < XW'(b_ff)) begin
               last_ff <= cur_ff;
               cur_ff  <= cur_ff + w_ff;
            end
         end
         ewh_pkg::ST_IDLE: begin
            if (accept) begin
               key_ff   <= v_key;
               rbin_ff  <= req.read_bin;
               rd_ok_ff <= rd_ok;
               idx_ff   <= '0;
               if (req.func) begin
                  kind_ff <= ewh_pkg::KIND_READ;
               end else if (req.is_null) begin
                  kind_ff <= ewh_pkg::KIND_NULL;
                  if (null_ff != {COUNT_WIDTH{1'b1}}) begin
                     null_ff <= null_ff + 1'b1;
                  end
               end else begin
                  kind_ff <= ewh_pkg::KIND_ADD;
                  if (v_key < (min_ff ^ sgn_mask)) begin
                     min_ff <= req.value;
                  end
                  if (v_key > (max_ff ^ sgn_mask)) begin
                     max_ff <= req.value;
                  end
               end
            end
         end
         ewh_pkg::ST_SCAN: begin
            // Advance the bin number while the token keeps passing edges.
            if (!stop_any) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: ;
      endcase

      if (upd_fire) begin
         rsp_ff.null_total <= ewh_pkg::TOTAL_W'(null_ff);
         rsp_ff.seen_min   <= min_ff;
         rsp_ff.seen_max   <= max_ff;
         case (kind_ff)
            ewh_pkg::KIND_ADD: begin
               rsp_ff.bin_index <= ewh_pkg::BIN_W'(idx_ff);
               rsp_ff.bin_total <= ewh_pkg::TOTAL_W'(cnt_sat);
            end
            ewh_pkg::KIND_READ: begin
               rsp_ff.bin_index <= rbin_ff;
               rsp_ff.bin_total <= rd_ok_ff ? ewh_pkg::TOTAL_W'(ram_rdata) : '0;
            end
            default: begin
               rsp_ff.bin_index <= '0;
               rsp_ff.bin_total <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   // At most one token travels the chain.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones({tok_chain[NCELL:1], tail_ff}) <= 1)
      else $error("more than one scan token in the edge chain");

   // The scan never runs past the last cell.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ewh_pkg::ST_SCAN |-> XW'(idx_ff) <= XW'(NCELL))
      else $error("scan ran past the edge chain");

   // Counts change only in the fill sweep or on an add item.
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ewh_pkg::ST_FILL ||
                 (state_ff == ewh_pkg::ST_UPD && kind_ff == ewh_pkg::KIND_ADD))
      else $error("unexpected count write");

   // Once rebuilt, there is always at least one edge.
   a_edges: assert property (@(posedge clock) disable iff (reset)
      state_ff == ewh_pkg::ST_IDLE |-> n_ff != '0)
      else $error("no edges after rebuild");
`endif

endmodule

// File: src/ewh_ram.sv
`timescale 1ns / 1ps

module ewh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

// File: src/ewh_div.sv
`timescale 1ns / 1ps

module ewh_div #(
   parameter int DIV_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ewh_pkg::VAL_W-1:0] dividend,
   input  logic [DIV_W-1:0]         divisor,
   output logic                     done,
   output logic [ewh_pkg::VAL_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ewh_pkg::VAL_W + 1);

   logic [ewh_pkg::VAL_W-1:0] a_ff, a_in;
   logic [DIV_W-1:0]          rem_ff, rem_in, d_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]            rem2;
   logic                      ge;

   // One quotient bit per cycle, restoring.
   always_comb begin
      rem2    = {rem_ff, a_ff[ewh_pkg::VAL_W-1]};
      ge      = rem2 >= {1'b0, d_ff};
      a_in    = a_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[ewh_pkg::VAL_W-2:0], ge};
         rem_in = ge ? DIV_W'(rem2 - {1'b0, d_ff}) : DIV_W'(rem2);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ewh_pkg::VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = a_ff;

endmodule

// File: src/ewh_edge_cell.sv
`timescale 1ns / 1ps

module ewh_edge_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  ewh_pkg::edge_type         edge_in,
   output ewh_pkg::edge_type         edge_out,
   input  logic [ewh_pkg::VAL_W-1:0] key_in,
   input  logic                      tok_in,
   output logic                      tok_out,
   output logic                      stop_out
);

   ewh_pkg::edge_type edge_ff;
   logic              tok_ff;
   logic              hit;

   assign hit      = edge_ff.vld && (edge_ff.key <= key_in);
   assign tok_out  = tok_ff && hit;
   assign stop_out = tok_ff && !hit;
   assign edge_out = edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff      <= 1'b0;
         edge_ff.vld <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (shift_en) begin
            edge_ff.vld <= edge_in.vld;
         end
      end
      if (shift_en) begin
         edge_ff.key <= edge_in.key;
      end
   end

endmodule
